[src/fsme_pkg.sv]
`timescale 1ns / 1ps

package fsme_pkg;

   // Input actions
   localparam logic [2:0] ACT_EVENT    = 3'd0;
   localparam logic [2:0] ACT_START    = 3'd1;
   localparam logic [2:0] ACT_STOP     = 3'd2;
   localparam logic [2:0] ACT_RESET    = 3'd3;
   localparam logic [2:0] ACT_SET      = 3'd4;
   localparam logic [2:0] ACT_UPDATE   = 3'd5;
   localparam logic [2:0] ACT_WR_TRANS = 3'd6;
   localparam logic [2:0] ACT_WR_STATE = 3'd7;

   // Callback kinds
   localparam logic [2:0] CB_NONE   = 3'd0;
   localparam logic [2:0] CB_EXIT   = 3'd1;
   localparam logic [2:0] CB_ACTION = 3'd2;
   localparam logic [2:0] CB_ENTRY  = 3'd3;
   localparam logic [2:0] CB_UPDATE = 3'd4;

   // CSR indexes
   localparam logic [1:0] CSR_STATES_IN_USE = 2'd0;
   localparam logic [1:0] CSR_TRANS_IN_USE  = 2'd1;
   localparam logic [1:0] CSR_INIT_STATE    = 2'd2;

   localparam int CSR_DW = 8;
   localparam int MAX_REQS = 3;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] event_code;
      logic [7:0] state_key;
      logic [3:0] slot;
      logic       any_state;
      logic [7:0] next_state;
      logic       no_move;
      logic       has_transition_action;
      logic       has_enter;
      logic       has_exit;
      logic       has_update;
   } req_item_type;

   typedef struct packed {
      logic [2:0] callback_kind;
      logic [7:0] callback_ref;
      logic       changed;
      logic [7:0] present_state;
      logic       running;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] src;
      logic [7:0] ev;
      logic [7:0] dst;
      logic       any;
      logic       stay;
      logic       act;
   } trans_entry_type;

   typedef struct packed {
      logic [7:0] id;
      logic       on_in;
      logic       on_out;
      logic       on_tick;
   } state_entry_type;

   // One finished step: up to three callback requests plus shared status
   typedef struct packed {
      logic [MAX_REQS-1:0][2:0] kind;
      logic [MAX_REQS-1:0][7:0] cb_ref;
      logic [1:0]               cnt;
      logic                     changed;
      logic [7:0]               present_state;
      logic                     running;
   } rsp_batch_type;

endpackage

[src/fsme_mem.sv]
`timescale 1ns / 1ps

module fsme_mem #(
   parameter int W     = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[src/fsme_rsp_buf.sv]
`timescale 1ns / 1ps

module fsme_rsp_buf
   import fsme_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_batch_type batch,
   output logic          empty,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_data
);

   rsp_batch_type batch_ff;
   logic [1:0]    count_ff, count_in;
   logic [1:0]    ptr_ff, ptr_in;

   assign empty     = (count_ff == 2'd0);
   assign rsp_valid = !empty;

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (load && empty) begin
         count_in = batch.cnt;
         ptr_in   = 2'd0;
      end else if (rsp_valid && !rsp_stall) begin
         if (ptr_ff == count_ff - 2'd1) begin
            count_in = 2'd0;
            ptr_in   = 2'd0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         ptr_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && empty) begin
         batch_ff <= batch;
      end
   end

   always_comb begin
      rsp_data.callback_kind = batch_ff.kind[ptr_ff];
      rsp_data.callback_ref  = batch_ff.cb_ref[ptr_ff];
      rsp_data.changed       = batch_ff.changed;
      rsp_data.present_state = batch_ff.present_state;
      rsp_data.running       = batch_ff.running;
      rsp_data.last          = (ptr_ff == count_ff - 2'd1);
   end

endmodule

[src/table_driven_fsm_engine.sv]
// Programmable table-driven state machine engine.
// req_* : one command per transfer (event, start, stop, reset, set state,
//         update, or a write of one transition / state table slot).
// rsp_* : one to three callback requests per command, in order exit,
//         action, entry (or a single update); the final one has last set.
//         A command that requests nothing returns one item of kind none.
// csr_* : write-only registers (entries in use, initial state); to be
//         written by the user only while the engine is idle, which the
//         engine itself does not enforce.
// A table write, or any command that scans nothing, goes straight to the
// finish state and hands over to the result buffer; an event first searches
// the transitions and then looks up states, since the single read port of
// each table is scanned one entry a cycle.
// Throughput: one command at a time; req_stall is high from acceptance
// until the command's results are handed to the result buffer.
// Reset clears the registers, the current state (to 0) and the running
// flag; table contents stay undefined until written.
// A stalled receiver holds the result buffer; the next command may still
// be accepted and processed, and waits to hand over until it drains.
`timescale 1ns / 1ps

module table_driven_fsm_engine
   import fsme_pkg::*;
#(
   parameter int MAX_TRANSITIONS = 16,
   parameter int MAX_STATES      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_item_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_item_type      rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int TAW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int SAW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int TCW = $clog2(MAX_TRANSITIONS + 1);
   localparam int SCW = $clog2(MAX_STATES + 1);
   localparam int IW  = (TCW > SCW) ? TCW : SCW;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TSCAN  = 3'd1;
   localparam logic [2:0] S_SSCAN  = 3'd2;
   localparam logic [2:0] S_POST   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   // State lookup purpose
   localparam logic [1:0] LK_EXIT   = 2'd0;
   localparam logic [1:0] LK_ENTRY  = 2'd1;
   localparam logic [1:0] LK_UPDATE = 2'd2;

   // CSRs
   logic [4:0] states_in_use_ff;
   logic [4:0] trans_in_use_ff;
   logic [7:0] init_state_ff;

   // Sequencer and engine state
   logic [2:0]  state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]  cur_ff, cur_in;
   logic        running_ff, running_in;
   logic        changed_ff, changed_in;
   logic [7:0]  ev_ff, ev_in;
   logic [7:0]  key_ff, key_in;
   logic [1:0]  lk_ff, lk_in;
   logic        pend_act_ff, pend_act_in;
   logic [7:0]  pend_ref_ff, pend_ref_in;
   logic        pend_entry_ff, pend_entry_in;
   logic [7:0]  pend_target_ff, pend_target_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [2:0]  req_kind_ff [MAX_REQS];
   logic [7:0]  req_ref_ff  [MAX_REQS];

   logic        push_en;
   logic [2:0]  push_kind;
   logic [7:0]  push_ref;

   // Table ports
   logic            t_we, s_we;
   trans_entry_type t_wdata, t_rdata;
   state_entry_type s_wdata, s_rdata;
   logic [TAW-1:0]  t_waddr, t_raddr;
   logic [SAW-1:0]  s_waddr, s_raddr;

   logic [IW-1:0]   n_t, n_s;
   logic            t_match, s_flag;
   logic [2:0]      s_kind;
   logic [7:0]      target;

   logic            buf_empty, buf_load;
   rsp_batch_type   batch;

   logic req_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Effective entry counts, clamped to table depth
   assign n_t = (32'(trans_in_use_ff) >= MAX_TRANSITIONS) ? IW'(MAX_TRANSITIONS)
                                                          : IW'(trans_in_use_ff);
   assign n_s = (32'(states_in_use_ff) >= MAX_STATES) ? IW'(MAX_STATES)
                                                      : IW'(states_in_use_ff);

   // Table write path
   assign t_waddr = TAW'(req_data.slot);
   assign s_waddr = SAW'(req_data.slot);
   assign t_wdata = '{src: req_data.state_key, ev: req_data.event_code,
                      dst: req_data.next_state, any: req_data.any_state,
                      stay: req_data.no_move, act: req_data.has_transition_action};
   assign s_wdata = '{id: req_data.state_key, on_in: req_data.has_enter,
                      on_out: req_data.has_exit, on_tick: req_data.has_update};

   // Read address follows next index, so read data lines up with idx_ff
   assign t_raddr = idx_in[TAW-1:0];
   assign s_raddr = idx_in[SAW-1:0];

   fsme_mem #(
      .W     ($bits(trans_entry_type)),
      .DEPTH (MAX_TRANSITIONS)
   ) u_trans_mem (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   fsme_mem #(
      .W     ($bits(state_entry_type)),
      .DEPTH (MAX_STATES)
   ) u_state_mem (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // Shared compare for the entry under the scan index
   assign t_match = ((t_rdata.src == cur_ff) || t_rdata.any) && (t_rdata.ev == ev_ff);

   always_comb begin
      case (lk_ff)
         LK_EXIT: begin
            s_flag = s_rdata.on_out;
            s_kind = CB_EXIT;
         end
         LK_ENTRY: begin
            s_flag = s_rdata.on_in;
            s_kind = CB_ENTRY;
         end
         LK_UPDATE: begin
            s_flag = s_rdata.on_tick;
            s_kind = CB_UPDATE;
         end
         default: begin
            s_flag = 1'b0;
            s_kind = CB_NONE;
         end
      endcase
   end

   assign target = (req_data.action == ACT_RESET) ? init_state_ff : req_data.state_key;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cur_in         = cur_ff;
      running_in     = running_ff;
      changed_in     = changed_ff;
      ev_in          = ev_ff;
      key_in         = key_ff;
      lk_in          = lk_ff;
      pend_act_in    = pend_act_ff;
      pend_ref_in    = pend_ref_ff;
      pend_entry_in  = pend_entry_ff;
      pend_target_in = pend_target_ff;
      cnt_in         = cnt_ff;
      push_en        = 1'b0;
      push_kind      = CB_NONE;
      push_ref       = 8'd0;
      t_we           = 1'b0;
      s_we           = 1'b0;
      buf_load       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               changed_in    = 1'b0;
               cnt_in        = 2'd0;
               ev_in         = req_data.event_code;
               idx_in        = '0;
               pend_act_in   = 1'b0;
               pend_entry_in = 1'b0;
               key_in        = cur_ff;
               state_in      = S_FINISH;
               case (req_data.action)
                  ACT_EVENT: begin
                     if (running_ff) state_in = S_TSCAN;
                  end
                  ACT_START: begin
                     running_in = 1'b1;
                     lk_in      = LK_ENTRY;
                     state_in   = S_SSCAN;
                  end
                  ACT_STOP: begin
                     if (running_ff) begin
                        running_in = 1'b0;
                        lk_in      = LK_EXIT;
                        state_in   = S_SSCAN;
                     end
                  end
                  ACT_RESET, ACT_SET: begin
                     if (running_ff) begin
                        lk_in          = LK_EXIT;
                        pend_entry_in  = 1'b1;
                        pend_target_in = target;
                        state_in       = S_SSCAN;
                     end else begin
                        cur_in = target;
                     end
                  end
                  ACT_UPDATE: begin
                     if (running_ff) begin
                        lk_in    = LK_UPDATE;
                        state_in = S_SSCAN;
                     end
                  end
                  ACT_WR_TRANS: begin
                     t_we = (32'(req_data.slot) < MAX_TRANSITIONS);
                  end
                  ACT_WR_STATE: begin
                     s_we = (32'(req_data.slot) < MAX_STATES);
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_TSCAN: begin
            if (idx_ff >= n_t) begin
               state_in = S_FINISH;
            end else if (t_match) begin
               if (t_rdata.stay) begin
                  push_en   = t_rdata.act;
                  push_kind = CB_ACTION;
                  push_ref  = 8'(idx_ff);
                  state_in  = S_FINISH;
               end else begin
                  changed_in     = 1'b1;
                  pend_act_in    = t_rdata.act;
                  pend_ref_in    = 8'(idx_ff);
                  pend_entry_in  = 1'b1;
                  pend_target_in = t_rdata.dst;
                  key_in         = cur_ff;
                  lk_in          = LK_EXIT;
                  idx_in         = '0;
                  state_in       = S_SSCAN;
               end
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end

         S_SSCAN: begin
            if ((idx_ff >= n_s) || (s_rdata.id == key_ff)) begin
               // first matching slot wins; not found means no request
               if (idx_ff < n_s) begin
                  push_en   = s_flag;
                  push_kind = s_kind;
                  push_ref  = key_ff;
               end
               state_in = (lk_ff == LK_EXIT && pend_entry_ff) ? S_POST : S_FINISH;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end

         S_POST: begin
            // action between exit and entry, then move and look up entry
            push_en       = pend_act_ff;
            push_kind     = CB_ACTION;
            push_ref      = pend_ref_ff;
            cur_in        = pend_target_ff;
            key_in        = pend_target_ff;
            lk_in         = LK_ENTRY;
            pend_entry_in = 1'b0;
            idx_in        = '0;
            state_in      = S_SSCAN;
         end

         S_FINISH: begin
            if (buf_empty) begin
               buf_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_en) cnt_in = cnt_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         cur_ff           <= 8'd0;
         running_ff       <= 1'b0;
         changed_ff       <= 1'b0;
         cnt_ff           <= 2'd0;
         pend_entry_ff    <= 1'b0;
         pend_act_ff      <= 1'b0;
         lk_ff            <= LK_EXIT;
         states_in_use_ff <= 5'd0;
         trans_in_use_ff  <= 5'd0;
         init_state_ff    <= 8'd0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         running_ff    <= running_in;
         changed_ff    <= changed_in;
         cnt_ff        <= cnt_in;
         pend_entry_ff <= pend_entry_in;
         pend_act_ff   <= pend_act_in;
         lk_ff         <= lk_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STATES_IN_USE: states_in_use_ff <= csr_wdata[4:0];
               CSR_TRANS_IN_USE:  trans_in_use_ff  <= csr_wdata[4:0];
               CSR_INIT_STATE:    init_state_ff    <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      ev_ff          <= ev_in;
      key_ff         <= key_in;
      pend_ref_ff    <= pend_ref_in;
      pend_target_ff <= pend_target_in;
      if (push_en) begin
         req_kind_ff[cnt_ff] <= push_kind;
         req_ref_ff[cnt_ff]  <= push_ref;
      end
   end

   // Hand the finished step to the result buffer
   always_comb begin
      for (int i = 0; i < MAX_REQS; i++) begin
         batch.kind[i]   = req_kind_ff[i];
         batch.cb_ref[i] = req_ref_ff[i];
      end
      batch.cnt           = cnt_ff;
      batch.changed       = changed_ff;
      batch.present_state = cur_ff;
      batch.running       = running_ff;
      if (cnt_ff == 2'd0) begin
         batch.kind[0]   = CB_NONE;
         batch.cb_ref[0] = 8'd0;
         batch.cnt       = 2'd1;
      end
   end

   fsme_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (buf_load),
      .batch     (batch),
      .empty     (buf_empty),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Finished step reaches the output on the next cycle
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && buf_empty) |=> (state_ff == S_IDLE && rsp_valid))
      else $error("finished step not handed to result buffer");

   // Table writes never scan
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_data.action == ACT_WR_TRANS || req_data.action == ACT_WR_STATE))
      |=> (state_ff == S_FINISH))
      else $error("table write did not go straight to finish");

   // Running flag only moves on an accepted command
   a_running_stable: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(running_ff))
      else $error("running flag changed without a command");

endmodule

[tb/table_driven_fsm_engine_test.sv]
`timescale 1ns / 1ps

module table_driven_fsm_engine_test;
   import fsme_pkg::*;

   localparam int TRANS_DEPTH  = 16;
   localparam int STATE_DEPTH  = 16;
   localparam int MAX_WAIT     = 14;      // longest idle/stall draw per transfer
   localparam int CYCLE_LIMIT  = 400000;  // hard stop for a hung run
   localparam int DRAIN_CYCLES = 80;      // > one full scan plus result handoff
   localparam int SHOWN_ERRORS = 10;

   // Unmapped register index; a write there must leave the engine untouched
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // Directed event codes and state ids
   localparam logic [7:0] EV_GO      = 8'd10;   // 1 -> 2 with action, 2 -> 2 self
   localparam logic [7:0] EV_POKE    = 8'd20;   // any-state stay with action
   localparam logic [7:0] EV_AWAY    = 8'd30;   // 1 -> a state not in the table
   localparam logic [7:0] EV_NOBODY  = 8'd99;   // matches nothing directed
   localparam logic [7:0] EV_JUMP    = 8'd255;  // any-state full move to 255
   localparam logic [7:0] ST_HOME    = 8'd1;
   localparam logic [7:0] ST_NEXT    = 8'd2;
   localparam logic [7:0] ST_TOP     = 8'd255;
   localparam logic [7:0] ST_UNKNOWN = 8'd200;

   // ---------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every DUT input is known from time zero.
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_item_type      req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_item_type      rsp_data;
   logic              csr_we    = 1'b0;
   logic [1:0]        csr_index = CSR_STATES_IN_USE;
   logic [CSR_DW-1:0] csr_wdata = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   table_driven_fsm_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow of the engine: tables, current state, running flag, registers.
   // ---------------------------------------------------------------------
   trans_entry_type tr_table [TRANS_DEPTH];
   state_entry_type st_table [STATE_DEPTH];
   logic [7:0]      fsm_state      = '0;
   logic            fsm_running    = 1'b0;
   logic [4:0]      n_states_reg   = '0;
   logic [4:0]      n_trans_reg    = '0;
   logic [7:0]      init_state_reg = '0;

   // Callbacks predicted but not yet seen on the result channel, oldest first
   rsp_item_type    callback_queue [$];
   // Requests raised by the command being predicted
   logic [2:0]      step_kinds [$];
   logic [7:0]      step_refs [$];

   int req_calm;     // remaining transfers without idling, request side
   int rsp_calm;     // same for the result side
   int rsp_hold;     // stall cycles left after the last result transfer
   int error_count;
   int cycle_count;

   function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
         CSR_STATES_IN_USE: n_states_reg = val[4:0];
         CSR_TRANS_IN_USE:  n_trans_reg = val[4:0];
         CSR_INIT_STATE:    init_state_reg = val;
         default: ;
      endcase
   endfunction

   // Lowest slot among the searched entries holding this id, -1 if none.
   // Counts above the depth clamp to the depth.
   function automatic int locate_state(input logic [7:0] id);
      int n;
      int hit;
      n = (int'(n_states_reg) > STATE_DEPTH) ? STATE_DEPTH : int'(n_states_reg);
      hit = -1;
      for (int i = n - 1; i >= 0; i--)
         if (st_table[i].id == id) hit = i;
      return hit;
   endfunction

   // Queue an exit, entry or update request if the state asks for it
   function automatic void add_state_cb(input logic [2:0] kind, input logic [7:0] id);
      int   k;
      logic flag;
      k = locate_state(id);
      if (k < 0) return;
      case (kind)
         CB_EXIT:  flag = st_table[k].on_out;
         CB_ENTRY: flag = st_table[k].on_in;
         default:  flag = st_table[k].on_tick;
      endcase
      if (flag) begin
         step_kinds.push_back(kind);
         step_refs.push_back(id);
      end
   endfunction

   // Advance the shadow by one accepted command and queue the callbacks it
   // must produce; a command that requests nothing yields one "none" item.
   function automatic void predict_callbacks(input req_item_type c);
      int              n;
      bit              hit;
      bit              moved;
      trans_entry_type t;
      rsp_item_type    r;
      step_kinds.delete();
      step_refs.delete();
      hit = 1'b0;
      moved = 1'b0;
      case (c.action)
         ACT_EVENT: begin
            if (fsm_running) begin
               n = (int'(n_trans_reg) > TRANS_DEPTH) ? TRANS_DEPTH : int'(n_trans_reg);
               // first match in slot order wins
               for (int i = 0; i < n; i++) begin
                  t = tr_table[i];
                  if (!hit && (t.src == fsm_state || t.any) && t.ev == c.event_code) begin
                     hit = 1'b1;
                     if (!t.stay) add_state_cb(CB_EXIT, fsm_state);
                     if (t.act) begin
                        step_kinds.push_back(CB_ACTION);
                        step_refs.push_back(8'(i));
                     end
                     if (!t.stay) begin
                        fsm_state = t.dst;
                        add_state_cb(CB_ENTRY, fsm_state);
                        moved = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_START: begin
            fsm_running = 1'b1;
            add_state_cb(CB_ENTRY, fsm_state);
         end
         ACT_STOP: begin
            if (fsm_running) begin
               add_state_cb(CB_EXIT, fsm_state);
               fsm_running = 1'b0;
            end
         end
         ACT_RESET, ACT_SET: begin
            // stopped engine: state moves silently
            if (fsm_running) add_state_cb(CB_EXIT, fsm_state);
            fsm_state = (c.action == ACT_RESET) ? init_state_reg : c.state_key;
            if (fsm_running) add_state_cb(CB_ENTRY, fsm_state);
         end
         ACT_UPDATE: begin
            if (fsm_running) add_state_cb(CB_UPDATE, fsm_state);
         end
         ACT_WR_TRANS: begin
            tr_table[c.slot] = '{src: c.state_key, ev: c.event_code, dst: c.next_state,
                                 any: c.any_state, stay: c.no_move,
                                 act: c.has_transition_action};
         end
         default: begin
            st_table[c.slot] = '{id: c.state_key, on_in: c.has_enter, on_out: c.has_exit,
                                 on_tick: c.has_update};
         end
      endcase
      if (step_kinds.size() == 0) begin
         step_kinds.push_back(CB_NONE);
         step_refs.push_back(8'd0);
      end
      for (int k = 0; k < step_kinds.size(); k++) begin
         r.callback_kind = step_kinds[k];
         r.callback_ref  = step_refs[k];
         r.changed       = moved;
         r.present_state = fsm_state;
         r.running       = fsm_running;
         r.last          = (k == step_kinds.size() - 1);
         callback_queue.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   // Idle/stall length for one transfer; now and then a calm stretch of
   // back-to-back transfers.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Small pools so events actually hit table entries, with full-range
   // values mixed in to toggle every bit.
   function automatic logic [7:0] pick_state();
      return ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, 7)) : 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_event();
      return ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, 5)) : 8'($urandom);
   endfunction

   // Command with noise in every field the action does not use
   function automatic req_item_type cmd_of(input logic [2:0] act);
      logic [63:0]  noise;
      req_item_type c;
      noise = {$urandom, $urandom};
      c = noise[$bits(req_item_type)-1:0];
      c.action = act;
      return c;
   endfunction

   function automatic req_item_type trans_cmd(input logic [3:0] slot, input logic [7:0] src,
                                              input logic [7:0] ev, input logic [7:0] dst,
                                              input logic any, input logic stay,
                                              input logic act);
      req_item_type c;
      c = cmd_of(ACT_WR_TRANS);
      c.slot = slot;
      c.state_key = src;
      c.event_code = ev;
      c.next_state = dst;
      c.any_state = any;
      c.no_move = stay;
      c.has_transition_action = act;
      return c;
   endfunction

   function automatic req_item_type state_cmd(input logic [3:0] slot, input logic [7:0] id,
                                              input logic on_in, input logic on_out,
                                              input logic on_tick);
      req_item_type c;
      c = cmd_of(ACT_WR_STATE);
      c.slot = slot;
      c.state_key = id;
      c.has_enter = on_in;
      c.has_exit = on_out;
      c.has_update = on_tick;
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one transfer per call. Valid stays up across back-to-back
   // transfers and drops when a gap is drawn, before register writes and at the final drain.
   // ---------------------------------------------------------------------
   task automatic send_cmd(input req_item_type c);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall);
      predict_callbacks(c);
   endtask

   task automatic send_event(input logic [7:0] ev);
      req_item_type c;
      c = cmd_of(ACT_EVENT);
      c.event_code = ev;
      send_cmd(c);
   endtask

   task automatic send_set(input logic [7:0] id);
      req_item_type c;
      c = cmd_of(ACT_SET);
      c.state_key = id;
      send_cmd(c);
   endtask

   // Register writes happen only with the engine drained. Write enable is
   // held across consecutive writes and dropped once at the end.
   task automatic program_regs(input logic [7:0] states_val, input logic [7:0] trans_val,
                               input logic [7:0] init_val, input bit poke_spare);
      logic [1:0] idx [$];
      logic [7:0] val [$];
      req_valid <= 1'b0;
      while (callback_queue.size() != 0) @(posedge clock);
      if (poke_spare) begin
         idx.push_back(CSR_SPARE);
         val.push_back(8'($urandom));
      end
      idx.push_back(CSR_STATES_IN_USE);
      val.push_back(states_val);
      idx.push_back(CSR_TRANS_IN_USE);
      val.push_back(trans_val);
      idx.push_back(CSR_INIT_STATE);
      val.push_back(init_val);
      for (int k = 0; k < idx.size(); k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         apply_reg(idx[k], val[k]);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly events on a running engine, with enough start/stop/reset/set
   // and table rewrites to keep the tables and state moving.
   task automatic random_burst(input int count);
      req_item_type c;
      int           roll;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            c = cmd_of(ACT_EVENT);
            c.event_code = pick_event();
         end else if (roll < 58) begin
            c = cmd_of(ACT_START);
         end else if (roll < 62) begin
            c = cmd_of(ACT_STOP);
         end else if (roll < 68) begin
            c = cmd_of(ACT_RESET);
         end else if (roll < 76) begin
            c = cmd_of(ACT_SET);
            c.state_key = pick_state();
         end else if (roll < 86) begin
            c = cmd_of(ACT_UPDATE);
         end else if (roll < 93) begin
            c = trans_cmd(4'($urandom), pick_state(), pick_event(), pick_state(),
                          ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                          1'($urandom));
         end else begin
            c = state_cmd(4'($urandom), pick_state(), 1'($urandom), 1'($urandom),
                          1'($urandom));
         end
         send_cmd(c);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: check every transfer against the oldest prediction, then
   // draw how long to stall before taking the next one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (callback_queue.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
               $display("unexpected callback transfer: kind %0d ref %0d state %0d",
                        rsp_data.callback_kind, rsp_data.callback_ref,
                        rsp_data.present_state);
         end else begin
            want = callback_queue.pop_front();
            if (rsp_data !== want) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("callback mismatch: kind %0d/%0d ref %0d/%0d changed %0d/%0d",
                           want.callback_kind, rsp_data.callback_kind,
                           want.callback_ref, rsp_data.callback_ref,
                           want.changed, rsp_data.changed,
                           " state %0d/%0d running %0d/%0d last %0d/%0d (expected/actual)",
                           want.present_state, rsp_data.present_state,
                           want.running, rsp_data.running,
                           want.last, rsp_data.last);
            end
         end
         rsp_hold = draw_wait(rsp_calm);
         if (rsp_hold > 0) rsp_stall <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_stall <= 1'b0;
      end
   end

   // Hard stop in case the engine hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Define every table slot first so no search ever reads an unwritten one.
   task automatic test_table_fill();
      for (int k = 0; k < TRANS_DEPTH; k++)
         send_cmd(trans_cmd(4'(k), pick_state(), pick_event(), pick_state(),
                            ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                            1'($urandom)));
      for (int k = 0; k < STATE_DEPTH; k++)
         send_cmd(state_cmd(4'(k), pick_state(), 1'($urandom), 1'($urandom), 1'($urandom)));
   endtask

   // Stopped engine: events and update ignored, stop is a no-op, reset and
   // set state move silently.
   task automatic test_stopped_engine();
      program_regs(8'd16, 8'd16, ST_HOME, 1'b0);
      send_event(pick_event());
      send_cmd(cmd_of(ACT_UPDATE));
      send_cmd(cmd_of(ACT_STOP));
      send_set(ST_UNKNOWN);
      send_cmd(cmd_of(ACT_RESET));   // back to ST_HOME
   endtask

   // Hand-built tables that walk every callback path
   task automatic test_callback_paths();
      send_cmd(state_cmd(4'd0, ST_HOME, 1'b1, 1'b1, 1'b1));
      send_cmd(state_cmd(4'd1, ST_NEXT, 1'b1, 1'b1, 1'b0));
      send_cmd(state_cmd(4'd2, ST_HOME, 1'b0, 1'b0, 1'b0));   // duplicate id, shadowed
      send_cmd(state_cmd(4'd3, ST_TOP, 1'b1, 1'b1, 1'b1));
      send_cmd(trans_cmd(4'd0, ST_HOME, EV_GO, ST_NEXT, 1'b0, 1'b0, 1'b1));
      send_cmd(trans_cmd(4'd1, ST_NEXT, EV_GO, ST_NEXT, 1'b0, 1'b0, 1'b0));   // self
      send_cmd(trans_cmd(4'd2, 8'd0, EV_POKE, 8'd0, 1'b1, 1'b1, 1'b1));      // stay
      send_cmd(trans_cmd(4'd3, ST_HOME, EV_AWAY, ST_UNKNOWN, 1'b0, 1'b0, 1'b1));
      send_cmd(trans_cmd(4'd4, 8'd0, EV_JUMP, ST_TOP, 1'b1, 1'b0, 1'b1));
      send_cmd(cmd_of(ACT_START));
      send_cmd(cmd_of(ACT_START));   // start again re-requests entry
      send_cmd(cmd_of(ACT_UPDATE));
      send_event(EV_POKE);           // action only
      send_event(EV_GO);             // exit, action, entry
      send_event(EV_GO);             // self transition: exit and entry
      send_cmd(cmd_of(ACT_UPDATE));  // state without update callback
      send_event(EV_NOBODY);
      send_event(EV_JUMP);
      send_set(ST_HOME);
      send_event(EV_AWAY);           // target has no state entry
      send_cmd(cmd_of(ACT_RESET));
      send_cmd(cmd_of(ACT_STOP));
   endtask

   // Register extremes, oversize counts and upper data bits that must drop
   task automatic test_register_extremes();
      program_regs(8'd0, 8'd0, 8'hFF, 1'b1);
      random_burst(40);
      program_regs(8'd31, 8'd31, 8'd0, 1'b0);
      random_burst(40);
      program_regs(8'd16, 8'd16, 8'($urandom), 1'b0);
      random_burst(40);
      program_regs(8'd1, 8'd1, pick_state(), 1'b0);
      random_burst(40);
      program_regs(8'hE4, 8'hF9, pick_state(), 1'b0);
      random_burst(40);
   endtask

   task automatic test_random_traffic();
      logic [7:0] n_s;
      logic [7:0] n_t;
      for (int phase = 0; phase < 5; phase++) begin
         n_s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(4, 16));
         n_t = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(4, 16));
         program_regs(n_s, n_t, pick_state(), 1'b0);
         random_burst(40);
      end
   endtask

   // Drain, let any stray result show up, then report
   task automatic finish_run();
      req_valid <= 1'b0;
      while (callback_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && callback_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_table_fill();
      test_stopped_engine();
      test_callback_paths();
      test_register_extremes();
      test_random_traffic();
      finish_run();
   end

endmodule
